### hw/rtl/c8ie_pkg.sv
// Shared types and constants for the CHIP-8 instruction execute unit.
// Holds the port words, the decoded word that crosses the queue and the opcode codes.
// No dependencies.
package c8ie_pkg;

	localparam logic [11:0] START_RESET = 12'd512;

	// flag register number
	localparam logic [3:0] VF_IDX = 4'hF;

	// call stack
	localparam int STACK_DEPTH = 16;
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// decoded-word queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);

	// full-word system opcodes
	localparam logic [15:0] OPC_CLS = 16'h00E0;
	localparam logic [15:0] OPC_RET = 16'h00EE;

	// major opcode nibble
	localparam logic [3:0] MAJ_SYS  = 4'h0;
	localparam logic [3:0] MAJ_JP   = 4'h1;
	localparam logic [3:0] MAJ_CALL = 4'h2;
	localparam logic [3:0] MAJ_SEI  = 4'h3;
	localparam logic [3:0] MAJ_SNEI = 4'h4;
	localparam logic [3:0] MAJ_SER  = 4'h5;
	localparam logic [3:0] MAJ_LDI  = 4'h6;
	localparam logic [3:0] MAJ_ADDI = 4'h7;
	localparam logic [3:0] MAJ_ALU  = 4'h8;
	localparam logic [3:0] MAJ_SNER = 4'h9;
	localparam logic [3:0] MAJ_LDX  = 4'hA;
	localparam logic [3:0] MAJ_JPV0 = 4'hB;
	localparam logic [3:0] MAJ_RND  = 4'hC;

	// 8xy low nibble
	localparam logic [3:0] SUB_MOV  = 4'h0;
	localparam logic [3:0] SUB_OR   = 4'h1;
	localparam logic [3:0] SUB_AND  = 4'h2;
	localparam logic [3:0] SUB_XOR  = 4'h3;
	localparam logic [3:0] SUB_ADD  = 4'h4;
	localparam logic [3:0] SUB_SUB  = 4'h5;
	localparam logic [3:0] SUB_SHR  = 4'h6;
	localparam logic [3:0] SUB_SUBN = 4'h7;
	localparam logic [3:0] SUB_SHL  = 4'hE;

	typedef enum logic [3:0] {
		K_CLS, K_RET, K_JP, K_CALL, K_SEI, K_SNEI, K_SER, K_SNER,
		K_LDI, K_ADDI, K_ALU, K_LDX, K_JPV0, K_RND, K_UNSUP
	} op_class_t;

	typedef enum logic [3:0] {
		A_MOV, A_OR, A_AND, A_XOR, A_ADD, A_SUB, A_SHR, A_SUBN, A_SHL
	} alu_op_t;

	typedef struct packed {
		logic [15:0] opcode;
		logic [7:0]  random_byte;
	} in_word_t;

	typedef struct packed {
		logic [11:0] fetch_address;
		logic [11:0] index_value;
		logic        reg_write;
		logic [3:0]  reg_index;
		logic [7:0]  reg_value;
		logic        flag_write;
		logic        flag_value;
		logic        clear_screen;
		logic        stack_error;
		logic        unsupported;
	} out_word_t;

	typedef struct packed {
		op_class_t   kind;
		alu_op_t     alu;
		logic [3:0]  x;
		logic [3:0]  y;
		logic [11:0] nnn;
		logic [7:0]  rnd;
	} dec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

### hw/rtl/c8ie_front.sv
// Front end: classifies one incoming instruction word into a decoded word.
// Depends on c8ie_pkg.
module c8ie_front (
	input  c8ie_pkg::in_word_t in_word,
	output c8ie_pkg::dec_t     dec
);

	logic [15:0] op;

	assign op = in_word.opcode;

	always_comb begin
		dec.kind = c8ie_pkg::K_UNSUP;
		dec.alu  = c8ie_pkg::A_MOV;
		dec.x    = op[11:8];
		dec.y    = op[7:4];
		dec.nnn  = op[11:0];
		dec.rnd  = in_word.random_byte;
		unique case (op[15:12])
			c8ie_pkg::MAJ_SYS: begin
				if (op == c8ie_pkg::OPC_CLS) dec.kind = c8ie_pkg::K_CLS;
				else if (op == c8ie_pkg::OPC_RET) dec.kind = c8ie_pkg::K_RET;
				else dec.kind = c8ie_pkg::K_UNSUP;
			end
			c8ie_pkg::MAJ_JP:   dec.kind = c8ie_pkg::K_JP;
			c8ie_pkg::MAJ_CALL: dec.kind = c8ie_pkg::K_CALL;
			c8ie_pkg::MAJ_SEI:  dec.kind = c8ie_pkg::K_SEI;
			c8ie_pkg::MAJ_SNEI: dec.kind = c8ie_pkg::K_SNEI;
			c8ie_pkg::MAJ_SER:  dec.kind = c8ie_pkg::K_SER;
			c8ie_pkg::MAJ_LDI:  dec.kind = c8ie_pkg::K_LDI;
			c8ie_pkg::MAJ_ADDI: dec.kind = c8ie_pkg::K_ADDI;
			c8ie_pkg::MAJ_ALU: begin
				dec.kind = c8ie_pkg::K_ALU;
				unique case (op[3:0])
					c8ie_pkg::SUB_MOV:  dec.alu = c8ie_pkg::A_MOV;
					c8ie_pkg::SUB_OR:   dec.alu = c8ie_pkg::A_OR;
					c8ie_pkg::SUB_AND:  dec.alu = c8ie_pkg::A_AND;
					c8ie_pkg::SUB_XOR:  dec.alu = c8ie_pkg::A_XOR;
					c8ie_pkg::SUB_ADD:  dec.alu = c8ie_pkg::A_ADD;
					c8ie_pkg::SUB_SUB:  dec.alu = c8ie_pkg::A_SUB;
					c8ie_pkg::SUB_SHR:  dec.alu = c8ie_pkg::A_SHR;
					c8ie_pkg::SUB_SUBN: dec.alu = c8ie_pkg::A_SUBN;
					c8ie_pkg::SUB_SHL:  dec.alu = c8ie_pkg::A_SHL;
					default:            dec.kind = c8ie_pkg::K_UNSUP;
				endcase
			end
			c8ie_pkg::MAJ_SNER: dec.kind = c8ie_pkg::K_SNER;
			c8ie_pkg::MAJ_LDX:  dec.kind = c8ie_pkg::K_LDX;
			c8ie_pkg::MAJ_JPV0: dec.kind = c8ie_pkg::K_JPV0;
			c8ie_pkg::MAJ_RND:  dec.kind = c8ie_pkg::K_RND;
			default:            dec.kind = c8ie_pkg::K_UNSUP;
		endcase
	end

endmodule

### hw/rtl/c8ie_queue.sv
// Short FIFO of decoded words between the front end and the execute stage.
// Depends on c8ie_pkg.
module c8ie_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  c8ie_pkg::dec_t       push_word,
	input  logic                 pop,
	output c8ie_pkg::dec_t       head,
	output c8ie_pkg::q_status_t  status
);

	c8ie_pkg::dec_t               mem_q [c8ie_pkg::Q_DEPTH];
	logic [c8ie_pkg::Q_AW-1:0]   wp_q;
	logic [c8ie_pkg::Q_AW-1:0]   rp_q;
	logic [c8ie_pkg::Q_CW-1:0]   cnt_q;

	assign status.full  = (cnt_q == c8ie_pkg::Q_CW'(c8ie_pkg::Q_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_word;
	end

endmodule

### hw/rtl/c8ie_back.sv
// Execute stage: register file, index, program counter, call stack, result register.
// Depends on c8ie_pkg; fed from c8ie_queue.
module c8ie_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [11:0]          cfg_data,
	input  c8ie_pkg::dec_t       head,
	input  logic                 head_valid,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output c8ie_pkg::out_word_t  out_word
);

	logic [11:0]               start_q;
	logic                      pc_live_q;
	logic [11:0]               pc_q;
	logic [11:0]               idx_q;
	logic [7:0]                gr_q [16];
	logic [11:0]               stk_q [c8ie_pkg::STACK_DEPTH];
	logic [c8ie_pkg::SP_W-1:0] sp_q;
	logic                      out_valid_q;
	c8ie_pkg::out_word_t       out_q;

	logic [7:0]                vx, vy, v0, nn;
	logic [11:0]               pc2, pc4, pc_nx, idx_nx;
	logic [8:0]                sum9;
	logic                      rw, fw, fval, cls, serr, unsup, push_stk, pop_stk;
	logic [7:0]                rval;
	logic [c8ie_pkg::SP_W-1:0] sp_m1;

	assign vx    = gr_q[head.x];
	assign vy    = gr_q[head.y];
	assign v0    = gr_q[0];
	assign nn    = head.nnn[7:0];
	assign pc2   = pc_q + 12'd2;
	assign pc4   = pc_q + 12'd4;
	assign sum9  = {1'b0, vx} + {1'b0, vy};
	assign sp_m1 = sp_q - 1'b1;

	// a new word moves in when one is queued, the PC is live and the result register is free or being drained
	assign pop = head_valid && pc_live_q && (!out_valid_q || !out_stall);

	always_comb begin
		pc_nx    = pc2;
		idx_nx   = idx_q;
		rw       = 1'b0;
		rval     = '0;
		fw       = 1'b0;
		fval     = 1'b0;
		cls      = 1'b0;
		serr     = 1'b0;
		unsup    = 1'b0;
		push_stk = 1'b0;
		pop_stk  = 1'b0;
		unique case (head.kind)
			c8ie_pkg::K_CLS: cls = 1'b1;
			c8ie_pkg::K_RET: begin
				if (sp_q == '0) serr = 1'b1;
				else begin
					pop_stk = 1'b1;
					pc_nx   = stk_q[sp_m1[c8ie_pkg::STK_AW-1:0]];
				end
			end
			c8ie_pkg::K_JP: pc_nx = head.nnn;
			c8ie_pkg::K_CALL: begin
				if (sp_q >= c8ie_pkg::SP_W'(c8ie_pkg::STACK_DEPTH)) serr = 1'b1;
				else begin
					push_stk = 1'b1;
					pc_nx    = head.nnn;
				end
			end
			c8ie_pkg::K_SEI:  if (vx == nn) pc_nx = pc4;
			c8ie_pkg::K_SNEI: if (vx != nn) pc_nx = pc4;
			c8ie_pkg::K_SER:  if (vx == vy) pc_nx = pc4;
			c8ie_pkg::K_SNER: if (vx != vy) pc_nx = pc4;
			c8ie_pkg::K_LDI: begin
				rw   = 1'b1;
				rval = nn;
			end
			c8ie_pkg::K_ADDI: begin
				rw   = 1'b1;
				rval = vx + nn;
			end
			c8ie_pkg::K_ALU: begin
				rw = 1'b1;
				unique case (head.alu)
					c8ie_pkg::A_MOV: rval = vy;
					c8ie_pkg::A_OR:  rval = vx | vy;
					c8ie_pkg::A_AND: rval = vx & vy;
					c8ie_pkg::A_XOR: rval = vx ^ vy;
					c8ie_pkg::A_ADD: begin
						rval = sum9[7:0];
						fw   = 1'b1;
						fval = sum9[8];
					end
					c8ie_pkg::A_SUB: begin
						rval = vx - vy;
						fw   = 1'b1;
						fval = (vx >= vy);
					end
					c8ie_pkg::A_SHR: begin
						rval = {1'b0, vx[7:1]};
						fw   = 1'b1;
						fval = vx[0];
					end
					c8ie_pkg::A_SUBN: begin
						rval = vy - vx;
						fw   = 1'b1;
						fval = (vy >= vx);
					end
					c8ie_pkg::A_SHL: begin
						rval = {vx[6:0], 1'b0};
						fw   = 1'b1;
						fval = vx[7];
					end
					default: rw = 1'b0;
				endcase
			end
			c8ie_pkg::K_LDX:  idx_nx = head.nnn;
			c8ie_pkg::K_JPV0: pc_nx = head.nnn + {4'd0, v0};
			c8ie_pkg::K_RND: begin
				rw   = 1'b1;
				rval = head.rnd & nn;
			end
			c8ie_pkg::K_UNSUP: unsup = 1'b1;
			default: unsup = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= c8ie_pkg::START_RESET;
			pc_live_q   <= 1'b0;
			idx_q       <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 16; i++) gr_q[i] <= '0;
		end else begin
			if (cfg_we) start_q <= cfg_data;
			pc_live_q <= 1'b1;
			if (pop) begin
				idx_q <= idx_nx;
				if (push_stk) sp_q <= sp_q + 1'b1;
				else if (pop_stk) sp_q <= sp_m1;
				// VF takes the flag unless Vx is VF itself; then the result wins
				if (fw && !(rw && head.x == c8ie_pkg::VF_IDX))
					gr_q[c8ie_pkg::VF_IDX] <= {7'd0, fval};
				if (rw) gr_q[head.x] <= rval;
			end
			if (pop) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// PC picks up the start address in the first cycle out of reset
	always_ff @(posedge clk) begin
		if (!pc_live_q) pc_q <= start_q;
		else if (pop) pc_q <= pc_nx;
	end

	always_ff @(posedge clk) begin
		if (pop && push_stk) stk_q[sp_q[c8ie_pkg::STK_AW-1:0]] <= pc2;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.fetch_address <= pc_nx;
			out_q.index_value   <= idx_nx;
			out_q.reg_write     <= rw;
			out_q.reg_index     <= rw ? head.x : 4'd0;
			out_q.reg_value     <= rw ? rval : 8'd0;
			out_q.flag_write    <= fw;
			out_q.flag_value    <= fw & fval;
			out_q.clear_screen  <= cls;
			out_q.stack_error   <= serr;
			out_q.unsupported   <= unsup;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

### hw/rtl/chip8_instruction_execute_unit.sv
// CHIP-8 instruction execute unit, top level.
// Instantiates c8ie_front, c8ie_queue and c8ie_back; types from c8ie_pkg.
//
// Usage:
//   in channel  (in_valid / in_stall / in_word): one fetched opcode plus a random byte.
//   out channel (out_valid / out_stall / out_word): next fetch address, index register,
//   register and flag writes, clear-screen, stack error and unsupported bits.
//   cfg_we / cfg_data write the start address; write it only while the unit is idle.
// Flow: an accepted word is decoded combinationally and written into a 4-entry queue;
//   the execute stage takes it from the queue head and registers its result in the
//   output register, which drives out_valid.
// Throughput: one word per cycle while the output is not stalled, set by the execute
//   stage (8-bit ALU and register file read/write in the same cycle).
// Reset: registers, index and stack pointer clear; the program counter loads the start
//   address in the first cycle after reset is released.
// Stall: a stalled result holds in the output register; words keep collecting in the
//   queue and in_stall rises once the queue is full.
module chip8_instruction_execute_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  c8ie_pkg::in_word_t   in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output c8ie_pkg::out_word_t  out_word,
	input  logic                 cfg_we,
	input  logic [11:0]          cfg_data
);

	c8ie_pkg::dec_t      dec;
	c8ie_pkg::dec_t      head;
	c8ie_pkg::q_status_t q_st;
	logic                push, pop;

	assign in_stall = q_st.full;
	assign push     = in_valid && !q_st.full;

	c8ie_front u_front (
		.in_word (in_word),
		.dec     (dec)
	);

	c8ie_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (dec),
		.pop       (pop),
		.head      (head),
		.status    (q_st)
	);

	c8ie_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.head       (head),
		.head_valid (!q_st.empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word)
	);

endmodule
